// File: rtl/core/dqd_pkg.sv
// Shared constants, types and index helpers for the bounded deque.
package dqd_pkg;

    localparam int DEPTH = 16;
    localparam int LW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW = 32;

    localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    localparam logic [3:0] CMD_ADD_FRONT = 4'd0;
    localparam logic [3:0] CMD_ADD_BACK = 4'd1;
    localparam logic [3:0] CMD_DEL_FIRST = 4'd2;
    localparam logic [3:0] CMD_DEL_LAST = 4'd3;
    localparam logic [3:0] CMD_CLEAR = 4'd4;
    localparam logic [3:0] CMD_DEL_VALUE = 4'd5;
    localparam logic [3:0] CMD_DUMP_ALL = 4'd6;
    localparam logic [3:0] CMD_DUMP_FIRST = 4'd7;
    localparam logic [3:0] CMD_DUMP_LAST = 4'd8;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic rd_en;
        logic [AW-1:0] rd_addr;
        logic wr_en;
        logic [AW-1:0] wr_addr;
        logic signed [DW-1:0] wr_data;
    } mem_req_t;

    typedef struct packed {
        logic is_element;
        logic signed [DW-1:0] element_value;
        logic [1:0] status;
        logic last;
    } item_t;

    // Physical slot of logical position l in the ring that starts at h.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [LW-1:0] l);
        logic [LW:0] s;
        s = {{(LW + 1 - AW){1'b0}}, h} + {1'b0, l};
        if (s >= {1'b0, DEPTH_L})
        begin
            s = s - {1'b0, DEPTH_L};
        end
        return s[AW-1:0];
    endfunction

endpackage

// File: rtl/core/dqd_ram.sv
// Entry store: one write port, one read port with registered read data.
module dqd_ram (
    input  logic clk,
    input  dqd_pkg::mem_req_t req,
    output logic signed [dqd_pkg::DW-1:0] rdata
);

    logic signed [dqd_pkg::DW-1:0] mem_reg [dqd_pkg::DEPTH];
    logic signed [dqd_pkg::DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_reg[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rdata_reg <= mem_reg[req.rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/dqd_outreg.sv
// Output register holding one result item toward the downstream side.
module dqd_outreg (
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  dqd_pkg::item_t item,
    input  logic out_stall,
    output logic slot_free,
    output logic out_valid,
    output logic is_element,
    output logic signed [dqd_pkg::DW-1:0] element_value,
    output logic [1:0] status,
    output logic last
);

    logic valid_reg;
    logic valid_next;
    dqd_pkg::item_t item_reg;

    assign slot_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign out_valid = valid_reg;
    assign is_element = item_reg.is_element;
    assign element_value = item_reg.element_value;
    assign status = item_reg.status;
    assign last = item_reg.last;

endmodule

// File: rtl/core/dqd_ctrl.sv
// Command sequencer: ring pointers, search and shift sweeps, dump reads.
module dqd_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic [3:0] cmd,
    input  logic signed [dqd_pkg::DW-1:0] operand,
    output dqd_pkg::mem_req_t req,
    input  logic signed [dqd_pkg::DW-1:0] rdata,
    input  logic slot_free,
    output logic load,
    output dqd_pkg::item_t item
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DUMP,
        S_SRCH,
        S_SHIFT,
        S_STATUS
    } state_t;

    state_t state_reg, state_next;
    logic [dqd_pkg::AW-1:0] head_reg, head_next;
    logic [dqd_pkg::LW-1:0] len_reg, len_next;
    logic [dqd_pkg::LW-1:0] idx_reg, idx_next;
    logic [dqd_pkg::LW-1:0] cnt_reg, cnt_next;
    logic signed [dqd_pkg::DW-1:0] op_reg, op_next;
    logic [1:0] st_reg, st_next;

    logic in_acc;
    logic [dqd_pkg::DW-1:0] op_u;
    logic [dqd_pkg::LW-1:0] k;
    logic [dqd_pkg::LW-1:0] dump_cnt;
    logic [dqd_pkg::LW-1:0] dump_from;
    logic [dqd_pkg::LW-1:0] idx1;
    logic [dqd_pkg::LW:0] idx2;
    logic [dqd_pkg::AW-1:0] head_dec;
    logic [dqd_pkg::AW-1:0] head_inc;
    logic full;
    logic empty;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc = in_valid && !in_stall;
    assign op_u = operand;
    assign full = (len_reg == dqd_pkg::DEPTH_L);
    assign empty = (len_reg == '0);
    assign idx1 = idx_reg + 1'b1;
    assign idx2 = {1'b0, idx_reg} + 2'd2;
    assign head_dec = (head_reg == '0) ? dqd_pkg::LAST_SLOT : head_reg - 1'b1;
    assign head_inc = (head_reg == dqd_pkg::LAST_SLOT) ? '0 : head_reg + 1'b1;

    always_comb
    begin
        if (op_u[dqd_pkg::DW-1])
        begin
            k = '0;
        end
        else if (op_u > {{(dqd_pkg::DW - dqd_pkg::LW){1'b0}}, len_reg})
        begin
            k = len_reg;
        end
        else
        begin
            k = op_u[dqd_pkg::LW-1:0];
        end
    end

    always_comb
    begin
        case (cmd)
            dqd_pkg::CMD_DUMP_FIRST:
            begin
                dump_cnt = k;
                dump_from = '0;
            end
            dqd_pkg::CMD_DUMP_LAST:
            begin
                dump_cnt = k;
                dump_from = len_reg - k;
            end
            default:
            begin
                dump_cnt = len_reg;
                dump_from = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        head_next = head_reg;
        len_next = len_reg;
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        op_next = op_reg;
        st_next = st_reg;
        req = '0;
        load = 1'b0;
        item = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next = operand;
                    st_next = dqd_pkg::ST_OK;
                    state_next = S_STATUS;
                    case (cmd)
                        dqd_pkg::CMD_ADD_FRONT:
                        begin
                            if (full)
                            begin
                                st_next = dqd_pkg::ST_FULL;
                            end
                            else
                            begin
                                head_next = head_dec;
                                len_next = len_reg + 1'b1;
                                req.wr_en = 1'b1;
                                req.wr_addr = head_dec;
                                req.wr_data = operand;
                            end
                        end
                        dqd_pkg::CMD_ADD_BACK:
                        begin
                            if (full)
                            begin
                                st_next = dqd_pkg::ST_FULL;
                            end
                            else
                            begin
                                len_next = len_reg + 1'b1;
                                req.wr_en = 1'b1;
                                req.wr_addr = dqd_pkg::phys(head_reg, len_reg);
                                req.wr_data = operand;
                            end
                        end
                        dqd_pkg::CMD_DEL_FIRST:
                        begin
                            if (empty)
                            begin
                                st_next = dqd_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                head_next = head_inc;
                                len_next = len_reg - 1'b1;
                            end
                        end
                        dqd_pkg::CMD_DEL_LAST:
                        begin
                            if (empty)
                            begin
                                st_next = dqd_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                len_next = len_reg - 1'b1;
                            end
                        end
                        dqd_pkg::CMD_CLEAR:
                        begin
                            if (empty)
                            begin
                                st_next = dqd_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                len_next = '0;
                            end
                        end
                        dqd_pkg::CMD_DEL_VALUE:
                        begin
                            if (empty)
                            begin
                                st_next = dqd_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                idx_next = '0;
                                req.rd_en = 1'b1;
                                req.rd_addr = head_reg;
                                state_next = S_SRCH;
                            end
                        end
                        dqd_pkg::CMD_DUMP_ALL,
                        dqd_pkg::CMD_DUMP_FIRST,
                        dqd_pkg::CMD_DUMP_LAST:
                        begin
                            if (dump_cnt != '0)
                            begin
                                idx_next = dump_from;
                                cnt_next = dump_cnt;
                                req.rd_en = 1'b1;
                                req.rd_addr = dqd_pkg::phys(head_reg, dump_from);
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            st_next = dqd_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (slot_free)
                begin
                    load = 1'b1;
                    item.is_element = 1'b1;
                    item.element_value = rdata;
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg != 1'b1)
                    begin
                        idx_next = idx1;
                        req.rd_en = 1'b1;
                        req.rd_addr = dqd_pkg::phys(head_reg, idx1);
                    end
                    else
                    begin
                        st_next = dqd_pkg::ST_OK;
                        state_next = S_STATUS;
                    end
                end
            end
            S_SRCH:
            begin
                if (rdata == op_reg)
                begin
                    if (idx1 < len_reg)
                    begin
                        req.rd_en = 1'b1;
                        req.rd_addr = dqd_pkg::phys(head_reg, idx1);
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        len_next = len_reg - 1'b1;
                        st_next = dqd_pkg::ST_OK;
                        state_next = S_STATUS;
                    end
                end
                else if (idx1 < len_reg)
                begin
                    idx_next = idx1;
                    req.rd_en = 1'b1;
                    req.rd_addr = dqd_pkg::phys(head_reg, idx1);
                end
                else
                begin
                    st_next = dqd_pkg::ST_NOTFOUND;
                    state_next = S_STATUS;
                end
            end
            S_SHIFT:
            begin
                // rdata holds entry idx+1; it moves down into idx
                req.wr_en = 1'b1;
                req.wr_addr = dqd_pkg::phys(head_reg, idx_reg);
                req.wr_data = rdata;
                if (idx2 < {1'b0, len_reg})
                begin
                    idx_next = idx1;
                    req.rd_en = 1'b1;
                    req.rd_addr = dqd_pkg::phys(head_reg, idx2[dqd_pkg::LW-1:0]);
                end
                else
                begin
                    len_next = len_reg - 1'b1;
                    st_next = dqd_pkg::ST_OK;
                    state_next = S_STATUS;
                end
            end
            S_STATUS:
            begin
                if (slot_free)
                begin
                    load = 1'b1;
                    item.status = st_reg;
                    item.last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg <= '0;
            len_reg <= '0;
            idx_reg <= '0;
            cnt_reg <= '0;
            st_reg <= dqd_pkg::ST_OK;
            op_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg <= head_next;
            len_reg <= len_next;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            st_reg <= st_next;
            op_reg <= op_next;
        end
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= dqd_pkg::DEPTH_L)
        else $error("length beyond store depth");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> slot_free)
        else $error("result loaded into occupied output register");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> ({1'b0, idx_reg} + 2'd1 < {1'b0, len_reg}))
        else $error("shift position outside list");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && full && (cmd == dqd_pkg::CMD_ADD_FRONT || cmd == dqd_pkg::CMD_ADD_BACK))
        |=> (len_reg == dqd_pkg::DEPTH_L && st_reg == dqd_pkg::ST_FULL))
        else $error("add into full store changed length");

endmodule

// File: rtl/core/bounded_deque_with_value_delete.sv
// Top level of the bounded deque with delete-by-value.
// Holds up to 16 signed 32-bit values as a ring in a single-port-read RAM, so adds and
// deletes at either end only move the head pointer or length. One command is taken at a
// time; a dump of k entries makes one RAM read per element; delete-by-value scans front
// to back at one entry per cycle and then moves every later entry down one slot, one RAM
// read and write per cycle. Downstream stalls can hold dump and status transfers. Every
// command ends with one status transfer carrying last.
module bounded_deque_with_value_delete (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic [3:0] cmd,
    input  logic signed [31:0] operand,
    output logic out_valid,
    input  logic out_stall,
    output logic is_element,
    output logic signed [31:0] element_value,
    output logic [1:0] status,
    output logic last
);

    dqd_pkg::mem_req_t req;
    dqd_pkg::item_t item;
    logic signed [dqd_pkg::DW-1:0] rdata;
    logic slot_free;
    logic load;

    dqd_ram u_ram (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    dqd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .operand   (operand),
        .req       (req),
        .rdata     (rdata),
        .slot_free (slot_free),
        .load      (load),
        .item      (item)
    );

    dqd_outreg u_outreg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .item          (item),
        .out_stall     (out_stall),
        .slot_free     (slot_free),
        .out_valid     (out_valid),
        .is_element    (is_element),
        .element_value (element_value),
        .status        (status),
        .last          (last)
    );

endmodule
